// File: design/cfcd_pkg.sv
// Package for the command frame CRC decoder.
// Frame layout constants, register indexes, status codes and widths.
// No dependencies; compiled first.
`default_nettype none

package cfcd_pkg;

  localparam int unsigned FrameLen = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] SleepKey = 16'hABCD;
  localparam logic [7:0]  CrcPoly  = 8'h8C;

  localparam logic [7:0]  HeaderReset  = 8'hCC;
  localparam logic [7:0]  VersionReset = 8'h01;
  localparam logic [15:0] DevIdReset   = 16'h0000;
  localparam logic [15:0] DefAddrReset = 16'h0001;

  localparam logic [7:0] CmdReset   = 8'd0;
  localparam logic [7:0] CmdSetAddr = 8'd1;
  localparam logic [7:0] CmdSleep   = 8'd255;

  // frame byte positions
  localparam logic [CountW-1:0] PosHeader  = CountW'(0);
  localparam logic [CountW-1:0] PosCommand = CountW'(1);
  localparam logic [CountW-1:0] PosVersion = CountW'(2);
  localparam logic [CountW-1:0] PosIdHi    = CountW'(3);
  localparam logic [CountW-1:0] PosIdLo    = CountW'(4);
  localparam logic [CountW-1:0] PosArgHi   = CountW'(5);
  localparam logic [CountW-1:0] PosArgLo   = CountW'(6);
  localparam logic [CountW-1:0] PosLast    = CountW'(FrameLen - 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegHeader  = 2'd0,
    RegVersion = 2'd1,
    RegDevId   = 2'd2,
    RegDefAddr = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StNoAction   = 4'd0,
    StCrcError   = 4'd1,
    StBadHeader  = 4'd2,
    StUnknownCmd = 4'd3,
    StAddrReload = 4'd4,
    StAddrChange = 4'd5,
    StResetReq   = 4'd6,
    StSleepReq   = 4'd7,
    StAsleep     = 4'd8
  } status_e;

endpackage

`default_nettype wire

// File: design/cfcd_if.sv
// Valid/ready channel interfaces for the command frame CRC decoder.
// Depends on cfcd_pkg for the status type.
`default_nettype none

interface cfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_first;

  modport source (output valid, frame_byte, frame_first, input ready);
  modport sink   (input valid, frame_byte, frame_first, output ready);
endinterface

interface cfcd_out_if;
  logic                  valid;
  logic                  ready;
  cfcd_pkg::status_e     status;
  logic [15:0]           address;

  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

`default_nettype wire

// File: design/cfcd_crc8.sv
// One-byte update of the reflected CRC-8 (polynomial 0x8C).
// Depends on cfcd_pkg for the polynomial.
`default_nettype none

module cfcd_crc8 (
  input  wire logic [7:0] crc_i,
  input  wire logic [7:0] data_i,
  output logic      [7:0] crc_o
);

  always_comb begin
    logic [7:0] c;
    c = crc_i ^ data_i;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ cfcd_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

// File: design/command_frame_crc_decoder.sv
// Top level of the command frame CRC decoder.
// Depends on cfcd_pkg, cfcd_in_if / cfcd_out_if and cfcd_crc8.
`default_nettype none

// Usage:
// - in_i carries one frame byte per transaction; frame_first restarts the
//   frame at position 0 and drops any partial frame without a result.
// - Each byte is handled in the cycle it is accepted: CRC update, field
//   capture, and on the last byte of a frame the command decode. The result
//   (status, address) is registered and offered on out_o the next cycle.
// - Throughput: one byte per cycle while in_i.ready is high. Only the last
//   byte of a frame gives a result; other bytes give no result.
// - One result register sits between the channels: in_i.ready is high while
//   that register is empty or being taken, so a stalled receiver holds up the
//   sender only while a result is waiting.
// - cfg_we_i/cfg_idx_i/cfg_data_i write the registers header_value (0),
//   version_value (1), device_id (2) and default_address (3). Writing
//   default_address also loads the current address. Write only while idle.
// - Reset (rst_ni low, asynchronous) restores register defaults, clears the
//   frame state and sleep latch, loads address 1 and empties the output.
// - Once a sleep command is taken, every later frame reports "ignored asleep".

module command_frame_crc_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cfcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [cfcd_pkg::CfgDataW-1:0] cfg_data_i,
  cfcd_in_if.sink                           in_i,
  cfcd_out_if.source                        out_o
);

  // configuration registers; default_address only loads the current address
  logic [7:0]  header_q, version_q;
  logic [15:0] dev_id_q;

  // frame state
  logic [cfcd_pkg::CountW-1:0] count_q, count_d;
  logic [7:0]  crc_q, crc_next;
  logic        head_ok_q, version_ok_q;
  logic [7:0]  cmd_q;
  logic [15:0] ident_q, arg_q;
  logic [15:0] addr_q, addr_d;
  logic        sleep_q, sleep_d;

  // result register
  logic                out_valid_q;
  cfcd_pkg::status_e   status_q, status_d;
  logic [15:0]         out_addr_q;

  logic                        in_fire;
  logic [cfcd_pkg::CountW-1:0] pos;
  logic                        is_last;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    if (in_i.frame_first || (count_q >= cfcd_pkg::CountW'(cfcd_pkg::FrameLen))) begin
      pos = cfcd_pkg::PosHeader;
    end else begin
      pos = count_q;
    end
  end

  assign is_last = (pos == cfcd_pkg::PosLast);
  assign count_d = is_last ? '0 : pos + cfcd_pkg::CountW'(1);

  cfcd_crc8 u_crc8 (
    .crc_i  ((pos == cfcd_pkg::PosHeader) ? 8'h00 : crc_q),
    .data_i (in_i.frame_byte),
    .crc_o  (crc_next)
  );

  // Frame-end decision; all header fields sit at positions before the last.
  always_comb begin
    status_d = cfcd_pkg::StNoAction;
    addr_d   = addr_q;
    sleep_d  = sleep_q;
    if (sleep_q) begin
      status_d = cfcd_pkg::StAsleep;
    end else if (crc_next != 8'h00) begin
      status_d = cfcd_pkg::StCrcError;
    end else if (!head_ok_q || !version_ok_q) begin
      status_d = cfcd_pkg::StBadHeader;
    end else begin
      case (cmd_q)
        cfcd_pkg::CmdReset: begin
          status_d = (ident_q == dev_id_q) ? cfcd_pkg::StResetReq : cfcd_pkg::StNoAction;
        end
        cfcd_pkg::CmdSetAddr: begin
          if ((ident_q == dev_id_q) && (arg_q != addr_q)) begin
            addr_d   = arg_q;
            status_d = cfcd_pkg::StAddrChange;
          end else begin
            status_d = cfcd_pkg::StAddrReload;
          end
        end
        cfcd_pkg::CmdSleep: begin
          if ((ident_q == dev_id_q) && (arg_q == cfcd_pkg::SleepKey)) begin
            sleep_d  = 1'b1;
            status_d = cfcd_pkg::StSleepReq;
          end else begin
            status_d = cfcd_pkg::StNoAction;
          end
        end
        default: begin
          status_d = cfcd_pkg::StUnknownCmd;
        end
      endcase
    end
  end

  // configuration, frame state and sleep latch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= cfcd_pkg::HeaderReset;
      version_q    <= cfcd_pkg::VersionReset;
      dev_id_q     <= cfcd_pkg::DevIdReset;
      count_q      <= '0;
      crc_q        <= '0;
      head_ok_q    <= 1'b0;
      version_ok_q <= 1'b0;
      cmd_q        <= '0;
      ident_q      <= '0;
      arg_q        <= '0;
      addr_q       <= cfcd_pkg::DefAddrReset;
      sleep_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfcd_pkg::RegHeader:  header_q  <= cfg_data_i[7:0];
          cfcd_pkg::RegVersion: version_q <= cfg_data_i[7:0];
          cfcd_pkg::RegDevId:   dev_id_q  <= cfg_data_i;
          cfcd_pkg::RegDefAddr: addr_q    <= cfg_data_i;
          default: ;
        endcase
      end else if (in_fire) begin
        count_q <= count_d;
        crc_q   <= crc_next;
        case (pos)
          cfcd_pkg::PosHeader:  head_ok_q     <= (in_i.frame_byte == header_q);
          cfcd_pkg::PosCommand: cmd_q         <= in_i.frame_byte;
          cfcd_pkg::PosVersion: version_ok_q  <= (in_i.frame_byte == version_q);
          cfcd_pkg::PosIdHi:    ident_q[15:8] <= in_i.frame_byte;
          cfcd_pkg::PosIdLo:    ident_q[7:0]  <= in_i.frame_byte;
          cfcd_pkg::PosArgHi:   arg_q[15:8]   <= in_i.frame_byte;
          cfcd_pkg::PosArgLo:   arg_q[7:0]    <= in_i.frame_byte;
          default: ;
        endcase
        if (is_last) begin
          addr_q  <= addr_d;
          sleep_q <= sleep_d;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_last) begin
      status_q   <= status_d;
      out_addr_q <= addr_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = status_q;
  assign out_o.address = out_addr_q;

  // a frame end while asleep always reports "ignored asleep"
  a_asleep_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_last && sleep_q) |=> (out_valid_q && status_q == cfcd_pkg::StAsleep))
    else $error("asleep frame did not report ignored asleep");

  // the address moves only on a config write or a frame end
  a_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && !(in_fire && is_last)) |=> $stable(addr_q))
    else $error("address changed outside a frame end or config write");

  // the byte counter stays inside the frame
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < cfcd_pkg::CountW'(cfcd_pkg::FrameLen))
    else $error("byte counter left the frame");

  // the sleep latch is only set together with a sleep-requested result
  a_sleep_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sleep_q) |-> (out_valid_q && status_q == cfcd_pkg::StSleepReq))
    else $error("sleep latch set without a sleep request result");

endmodule

`default_nettype wire

// File: dv/command_frame_crc_decoder_test.sv
// Self-checking test for command_frame_crc_decoder: byte stream stimulus with
// CRC-8 framed commands, a scoreboard that predicts status/address per frame.
// Depends on cfcd_pkg and the cfcd_in_if / cfcd_out_if channel interfaces.
module command_frame_crc_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkPeriod     = 8;
  localparam int          ResetCycles   = 11;
  localparam int unsigned BlockBytes    = 140;
  localparam int          DrainCycles   = 4;
  localparam int          TimeoutNs     = 2_000_000;

  typedef struct packed {
    cfcd_pkg::status_e status;
    logic [15:0]       address;
  } frame_result_t;

  // Tracks frame position, CRC and decoder state; queues the outcome of
  // every frame that completes.
  class frame_status_board;
    logic [7:0]                  hdr_cfg;
    logic [7:0]                  ver_cfg;
    logic [15:0]                 id_cfg;
    logic [cfcd_pkg::CountW-1:0] byte_count;
    logic [7:0]                  crc_acc;
    logic [7:0]                  cmd;
    logic [15:0]                 ident;
    logic [15:0]                 argument;
    logic [15:0]                 addr_now;
    bit                          head_ok;
    bit                          ver_ok;
    bit                          asleep;
    frame_result_t               expected_q[$];
    int unsigned                 errors;

    function new();
      hdr_cfg    = cfcd_pkg::HeaderReset;
      ver_cfg    = cfcd_pkg::VersionReset;
      id_cfg     = cfcd_pkg::DevIdReset;
      addr_now   = cfcd_pkg::DefAddrReset;
      byte_count = '0;
      crc_acc    = '0;
      cmd        = '0;
      ident      = '0;
      argument   = '0;
      head_ok    = 1'b0;
      ver_ok     = 1'b0;
      asleep     = 1'b0;
      errors     = 0;
    endfunction

    // reflected CRC-8, one byte, LSB first
    static function logic [7:0] crc8_maxim_byte(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ cfcd_pkg::CrcPoly) : (c >> 1);
      end
      return c;
    endfunction

    function void write_reg(cfcd_pkg::cfg_reg_e idx, logic [15:0] v);
      case (idx)
        cfcd_pkg::RegHeader:  hdr_cfg = v[7:0];
        cfcd_pkg::RegVersion: ver_cfg = v[7:0];
        cfcd_pkg::RegDevId:   id_cfg = v;
        cfcd_pkg::RegDefAddr: addr_now = v;
        default: ;
      endcase
    endfunction

    function cfcd_pkg::status_e judge_frame();
      if (asleep) return cfcd_pkg::StAsleep;
      if (crc_acc != 8'h00) return cfcd_pkg::StCrcError;
      if (!head_ok || !ver_ok) return cfcd_pkg::StBadHeader;
      case (cmd)
        cfcd_pkg::CmdReset: begin
          if (ident == id_cfg) return cfcd_pkg::StResetReq;
          return cfcd_pkg::StNoAction;
        end
        cfcd_pkg::CmdSetAddr: begin
          if (ident == id_cfg && argument != addr_now) begin
            addr_now = argument;
            return cfcd_pkg::StAddrChange;
          end
          return cfcd_pkg::StAddrReload;
        end
        cfcd_pkg::CmdSleep: begin
          if (ident == id_cfg && argument == cfcd_pkg::SleepKey) begin
            asleep = 1'b1;
            return cfcd_pkg::StSleepReq;
          end
          return cfcd_pkg::StNoAction;
        end
        default: return cfcd_pkg::StUnknownCmd;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic first);
      logic [cfcd_pkg::CountW-1:0] pos;
      frame_result_t               res;
      pos = first ? cfcd_pkg::PosHeader : byte_count;
      if (pos > cfcd_pkg::PosLast) pos = cfcd_pkg::PosHeader;
      if (pos == cfcd_pkg::PosHeader) crc_acc = 8'h00;
      crc_acc = crc8_maxim_byte(crc_acc, b);
      case (pos)
        cfcd_pkg::PosHeader:  head_ok = (b == hdr_cfg);
        cfcd_pkg::PosCommand: cmd = b;
        cfcd_pkg::PosVersion: ver_ok = (b == ver_cfg);
        cfcd_pkg::PosIdHi:    ident[15:8] = b;
        cfcd_pkg::PosIdLo:    ident[7:0] = b;
        cfcd_pkg::PosArgHi:   argument[15:8] = b;
        cfcd_pkg::PosArgLo:   argument[7:0] = b;
        default: ;
      endcase
      if (pos != cfcd_pkg::PosLast) begin
        byte_count = pos + cfcd_pkg::CountW'(1);
      end else begin
        byte_count  = '0;
        res.status  = judge_frame();
        res.address = addr_now;
        expected_q.push_back(res);
      end
    endfunction

    function void check_result(cfcd_pkg::status_e st, logic [15:0] addr);
      frame_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d address %h", st, addr);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (st !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, st);
          errors++;
        end
        if (addr !== exp_res.address) begin
          $error("address: expected %h, got %h", exp_res.address, addr);
          errors++;
        end
      end
    endfunction

    function bit at_frame_start();
      return byte_count == '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cfcd_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cfcd_pkg::CfgDataW-1:0] cfg_data;

  cfcd_in_if  in_if ();
  cfcd_out_if out_if ();

  command_frame_crc_decoder u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  frame_status_board board;
  int unsigned       src_idle_pct;
  int unsigned       sink_idle_pct;
  int unsigned       bytes_sent;
  logic [7:0]        frm [cfcd_pkg::FrameLen];

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) board.note_byte(in_if.frame_byte, in_if.frame_first);
      if (out_if.valid && out_if.ready) board.check_result(out_if.status, out_if.address);
    end
  end

  // free_first: on a frame boundary the start flag is optional, pick it at random
  task automatic send_byte(input logic [7:0] b, input logic first, input bit free_first);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    if (free_first && board.at_frame_start()) first = 1'($urandom_range(1));
    in_if.valid       = 1'b1;
    in_if.frame_byte  = b;
    in_if.frame_first = first;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic first0, input int unsigned n_bytes,
                            input bit free_first);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      send_byte(frm[i], (i == 0) ? first0 : 1'b0, free_first && (i == 0));
    end
  endtask

  // lowers valid, then holds off until every frame outcome has been seen
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfcd_pkg::cfg_reg_e idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, v);
  endtask

  // fill < 0 gives random padding bytes; last byte carries the CRC
  function automatic void build_frame(logic [7:0] hdr, logic [7:0] cmd, logic [7:0] ver,
                                      logic [15:0] id, logic [15:0] arg, int fill);
    logic [7:0] crc;
    frm[cfcd_pkg::PosHeader]  = hdr;
    frm[cfcd_pkg::PosCommand] = cmd;
    frm[cfcd_pkg::PosVersion] = ver;
    frm[cfcd_pkg::PosIdHi]    = id[15:8];
    frm[cfcd_pkg::PosIdLo]    = id[7:0];
    frm[cfcd_pkg::PosArgHi]   = arg[15:8];
    frm[cfcd_pkg::PosArgLo]   = arg[7:0];
    for (int i = cfcd_pkg::PosArgLo + 1; i < cfcd_pkg::PosLast; i++) begin
      frm[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    end
    crc = 8'h00;
    for (int i = 0; i < cfcd_pkg::PosLast; i++) begin
      crc = frame_status_board::crc8_maxim_byte(crc, frm[i]);
    end
    frm[cfcd_pkg::PosLast] = crc;
  endfunction

  function automatic void build_random_frame(bit allow_sleep);
    logic [7:0]  hdr;
    logic [7:0]  cmd;
    logic [7:0]  ver;
    logic [15:0] id;
    logic [15:0] arg;
    hdr = ($urandom_range(9) == 0) ? 8'($urandom) : board.hdr_cfg;
    ver = ($urandom_range(9) == 0) ? 8'($urandom) : board.ver_cfg;
    id  = ($urandom_range(9) < 7) ? board.id_cfg : 16'($urandom);
    case ($urandom_range(9))
      0, 1:       cmd = cfcd_pkg::CmdReset;
      2, 3, 4, 5: cmd = cfcd_pkg::CmdSetAddr;
      6, 7:       cmd = cfcd_pkg::CmdSleep;
      default:    cmd = 8'($urandom);
    endcase
    arg = 16'($urandom);
    if (cmd == cfcd_pkg::CmdSetAddr && $urandom_range(2) == 0) arg = board.addr_now;
    if (cmd == cfcd_pkg::CmdSleep && $urandom_range(1) == 0) arg = cfcd_pkg::SleepKey;
    // sleep latch only clears on reset, keep it for the last phase
    if (!allow_sleep && cmd == cfcd_pkg::CmdSleep && arg == cfcd_pkg::SleepKey
        && id == board.id_cfg) id = ~id;
    build_frame(hdr, cmd, ver, id, arg, -1);
    if ($urandom_range(9) == 0) frm[cfcd_pkg::PosLast] ^= 8'(1 << $urandom_range(7));
  endfunction

  task automatic random_traffic(input int unsigned budget, input bit allow_sleep);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        wait_drained();
      end else if (pick < 10) begin
        n = $urandom_range(20, 1);
        repeat (n) send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0);
      end else if (pick < 16) begin
        // truncated frame, dropped by the next start flag
        build_random_frame(1'b0);
        send_frame(1'b1, $urandom_range(cfcd_pkg::FrameLen - 1, 1), 1'b0);
      end else begin
        build_random_frame(allow_sleep);
        send_frame(1'b1, cfcd_pkg::FrameLen, 1'b1);
      end
    end
  endtask

  task automatic directed_frames();
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, cfcd_pkg::VersionReset,
                16'h0000, 16'h1234, -1);
    send_frame(1'b1, 5, 1'b0);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    // back-to-back frame without a start flag, wrong id
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, cfcd_pkg::VersionReset,
                16'hFFFF, 16'h0000, -1);
    send_frame(1'b0, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdReset, cfcd_pkg::VersionReset,
                16'h0000, 16'h5555, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdReset, cfcd_pkg::VersionReset,
                16'h00FF, 16'h5555, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, 8'h80, cfcd_pkg::VersionReset,
                16'h0000, 16'h0001, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, cfcd_pkg::VersionReset,
                16'h0000, 16'h4321, -1);
    frm[cfcd_pkg::PosLast] ^= 8'h80;
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(~cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, cfcd_pkg::VersionReset,
                16'h0000, 16'h4321, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, ~cfcd_pkg::VersionReset,
                16'h0000, 16'h4321, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSleep, cfcd_pkg::VersionReset,
                16'h0000, cfcd_pkg::SleepKey ^ 16'h0001, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSleep, cfcd_pkg::VersionReset,
                16'h0001, cfcd_pkg::SleepKey, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, cfcd_pkg::VersionReset,
                16'h0000, 16'h0000, 8'h00);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    build_frame(cfcd_pkg::HeaderReset, cfcd_pkg::CmdSetAddr, cfcd_pkg::VersionReset,
                16'h0000, 16'hFFFF, 8'hFF);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
  endtask

  initial begin
    logic [7:0]  hdr_v;
    logic [7:0]  ver_v;
    logic [15:0] id_v;
    logic [15:0] addr_v;
    int unsigned k;
    board             = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = cfcd_pkg::RegHeader;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.frame_byte  = 8'h00;
    in_if.frame_first = 1'b0;
    src_idle_pct      = 20;
    sink_idle_pct     = 59;
    bytes_sent        = 0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_frames();

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = (p == 0) ? 20 : (p == 1) ? 59 : 0;
      sink_idle_pct = (p == 0) ? 59 : (p == 1) ? 20 : 0;
      for (int blk = 0; blk < 2; blk++) begin
        k = p * 2 + blk;
        if (k == 0) begin
          {hdr_v, ver_v, id_v, addr_v} = '0;
        end else if (k == 1) begin
          {hdr_v, ver_v, id_v, addr_v} = '1;
        end else begin
          hdr_v  = 8'($urandom);
          ver_v  = 8'($urandom);
          id_v   = 16'($urandom);
          addr_v = 16'($urandom);
        end
        wait_drained();
        write_reg(cfcd_pkg::RegHeader, {8'h00, hdr_v});
        write_reg(cfcd_pkg::RegVersion, {8'h00, ver_v});
        write_reg(cfcd_pkg::RegDevId, id_v);
        write_reg(cfcd_pkg::RegDefAddr, addr_v);
        random_traffic(BlockBytes, 1'b0);
      end
    end

    // put the device to sleep; everything after reports it is ignored
    wait_drained();
    write_reg(cfcd_pkg::RegDevId, 16'($urandom));
    build_frame(board.hdr_cfg, cfcd_pkg::CmdSleep, board.ver_cfg, board.id_cfg,
                cfcd_pkg::SleepKey, -1);
    send_frame(1'b1, cfcd_pkg::FrameLen, 1'b0);
    random_traffic(96, 1'b1);
    wait_drained();
    write_reg(cfcd_pkg::RegDefAddr, 16'($urandom));
    random_traffic(48, 1'b1);

    wait_drained();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #TimeoutNs;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
